>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_HOLDS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_HOLDS(lbl, clk, rst, prop)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> rtl/cprf_pkg.sv
// ----------------------------------------------------------------------------
// cprf_pkg
// Types and codes shared by the command prefetch ring feeder.
// ----------------------------------------------------------------------------
package cprf_pkg;

  localparam logic [1:0] KIND_PAD     = 2'd0;
  localparam logic [1:0] KIND_PACKET  = 2'd1;
  localparam logic [1:0] KIND_PUBLISH = 2'd2;
  localparam logic [1:0] KIND_TRACE   = 2'd3;

  localparam logic [1:0] REG_IQ_BASE   = 2'd0;
  localparam logic [1:0] REG_TRACE_OP  = 2'd1;
  localparam logic [1:0] REG_PAD_OP    = 2'd2;

  localparam logic [7:0] TRACE_OP_RESET = 8'd1;
  localparam logic [7:0] PAD_OP_RESET   = 8'd2;

  typedef struct packed {
    logic [31:0] issue_queue_base;
    logic [7:0]  trace_opcode;
    logic [7:0]  pad_opcode;
  } cfg_t;

  typedef struct packed {
    logic [31:0] trace_length;
    logic [31:0] trace_source;
    logic [18:0] forward_bytes;
    logic [18:0] header_bytes;
    logic [7:0]  command_code;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  page;
    logic [6:0]  count;
    logic [31:0] published;
  } result_t;

  typedef struct packed {
    result_t [2:0] res;
    logic [1:0]    last;
  } bundle_t;

  typedef struct packed {
    logic valid;
    logic done;
  } out_status_t;

  function automatic result_t mk_result(logic [1:0] kind, logic [5:0] page,
                                        logic [6:0] count, logic [31:0] published);
    result_t r;
    r.kind      = kind;
    r.page      = page;
    r.count     = count;
    r.published = published;
    return r;
  endfunction

endpackage

>>> rtl/cprf_cfg.sv
// ----------------------------------------------------------------------------
// cprf_cfg
// APB register file: issue queue base, trace opcode, pad opcode.
// ----------------------------------------------------------------------------
module cprf_cfg import cprf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.issue_queue_base <= '0;
      cfg.trace_opcode     <= TRACE_OP_RESET;
      cfg.pad_opcode       <= PAD_OP_RESET;
    end else if (wr) begin
      case (paddr[3:2])
        REG_IQ_BASE:  cfg.issue_queue_base <= pwdata;
        REG_TRACE_OP: cfg.trace_opcode     <= pwdata[7:0];
        REG_PAD_OP:   cfg.pad_opcode       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_IQ_BASE:  prdata = cfg.issue_queue_base;
      REG_TRACE_OP: prdata = {24'd0, cfg.trace_opcode};
      REG_PAD_OP:   prdata = {24'd0, cfg.pad_opcode};
      default:      prdata = '0;
    endcase
  end

endmodule

>>> rtl/cprf_step.sv
// ----------------------------------------------------------------------------
// cprf_step
// Feeder state and the single-pass decision for one command header.
// ----------------------------------------------------------------------------
module cprf_step import cprf_pkg::*; #(
  parameter int PAGE_BYTES        = 4096,
  parameter int RING_PAGES        = 64,
  parameter int ISSUE_QUEUE_BYTES = 65536,
  parameter int ALIGN_BYTES       = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  req_t        req,
  input  logic        take,
  output bundle_t     bundle,
  output logic [63:0] read_pointer,
  output logic [31:0] next_fetch
);

  localparam int PB_LOG = $clog2(PAGE_BYTES);
  localparam int RPW    = $clog2(RING_PAGES);
  localparam int PCW    = $clog2(RING_PAGES + 1);
  localparam int PSW    = PCW + 1;
  localparam int IQW    = $clog2(ISSUE_QUEUE_BYTES);

  logic [RPW-1:0] ring_pos, ring_pos_next;
  logic [31:0]    put_pages, put_pages_next;
  logic [63:0]    read_pointer_next;
  logic [31:0]    trace_position, trace_position_next;
  logic [31:0]    trace_limit, trace_limit_next;
  logic           tracing, tracing_next;

  logic [19:0]    pages_raw;
  logic [PCW-1:0] pages, remaining, pos_sum;
  logic [PSW-1:0] pad_sum;
  logic [RPW-1:0] pos_base, pos_end;
  logic           need_pad, is_trace_cmd, is_pad_cmd, trace_done, publish;
  logic [31:0]    put_pad, put_pkt, tp_sum;
  logic [18:0]    rp_inc;
  result_t        r_pad, r_pkt, r_pub;

  // pages rounded up (page size is a power of two), clamped to ring size
  assign pages_raw = (20'(req.forward_bytes) + 20'(PAGE_BYTES - 1)) >> PB_LOG;
  assign pages     = (pages_raw > 20'(RING_PAGES)) ? PCW'(RING_PAGES) : PCW'(pages_raw);
  assign remaining = PCW'(RING_PAGES) - PCW'(ring_pos);
  assign need_pad  = remaining < pages;
  assign pad_sum   = PSW'(remaining) + PSW'(pages);
  assign pos_base  = need_pad ? '0 : ring_pos;
  assign pos_sum   = PCW'(pos_base) + pages;
  assign pos_end   = (pos_sum >= PCW'(RING_PAGES)) ? '0 : pos_sum[RPW-1:0];
  assign put_pad   = put_pages + 32'(remaining);
  assign put_pkt   = put_pages + (need_pad ? 32'(pad_sum) : 32'(pages));

  assign tp_sum     = trace_position + 32'(req.header_bytes);
  assign trace_done = tp_sum >= trace_limit;

  assign is_trace_cmd = !tracing && (req.command_code == cfg.trace_opcode);
  assign is_pad_cmd   = !tracing && !is_trace_cmd && (req.command_code == cfg.pad_opcode);
  assign publish      = !tracing || trace_done;

  assign r_pad = mk_result(KIND_PAD, 6'(ring_pos), 7'(remaining), put_pad);
  assign r_pkt = mk_result(KIND_PACKET, 6'(pos_base), 7'(pages), put_pkt);
  assign r_pub = mk_result(KIND_PUBLISH, 6'(pos_end), 7'd0, put_pkt);

  always_comb begin
    ring_pos_next       = ring_pos;
    put_pages_next      = put_pages;
    trace_position_next = trace_position;
    trace_limit_next    = trace_limit;
    tracing_next        = tracing;
    rp_inc              = '0;
    bundle.res          = {r_pub, r_pub, r_pub};
    bundle.last         = 2'd0;
    if (is_trace_cmd) begin
      trace_position_next = req.trace_source;
      trace_limit_next    = req.trace_source + req.trace_length;
      tracing_next        = 1'b1;
      bundle.res[0]       = mk_result(KIND_TRACE, 6'(ring_pos), 7'd0, put_pages);
    end else if (is_pad_cmd) begin
      rp_inc        = req.header_bytes;
      bundle.res[0] = mk_result(KIND_PUBLISH, 6'(ring_pos), 7'd0, put_pages);
    end else begin
      ring_pos_next  = pos_end;
      put_pages_next = put_pkt;
      if (tracing) begin
        trace_position_next = tp_sum;
        if (trace_done) begin
          tracing_next = 1'b0;
          rp_inc       = 19'(ALIGN_BYTES);
        end
      end else begin
        rp_inc = req.header_bytes;
      end
      if (need_pad) begin
        bundle.res[0] = r_pad;
        bundle.res[1] = r_pkt;
        bundle.last   = publish ? 2'd2 : 2'd1;
      end else begin
        bundle.res[0] = r_pkt;
        bundle.last   = publish ? 2'd1 : 2'd0;
      end
    end
  end

  assign read_pointer_next = read_pointer + 64'(rp_inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_pos       <= '0;
      put_pages      <= '0;
      read_pointer   <= '0;
      trace_position <= '0;
      trace_limit    <= '0;
      tracing        <= 1'b0;
    end else if (take) begin
      ring_pos       <= ring_pos_next;
      put_pages      <= put_pages_next;
      read_pointer   <= read_pointer_next;
      trace_position <= trace_position_next;
      trace_limit    <= trace_limit_next;
      tracing        <= tracing_next;
    end
  end

  assign next_fetch = tracing ? trace_position
                              : cfg.issue_queue_base + 32'(read_pointer[IQW-1:0]);

endmodule

>>> rtl/cprf_out.sv
// ----------------------------------------------------------------------------
// cprf_out
// Result register: holds one step's actions and hands them out in order.
// ----------------------------------------------------------------------------
module cprf_out import cprf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  bundle_t     bundle_next,
  input  logic        m_ready,
  output out_status_t status,
  output result_t     cur,
  output logic        last
);

  bundle_t    bundle;
  logic       valid;
  logic [1:0] slot;

  assign last        = slot == bundle.last;
  assign cur         = bundle.res[slot];
  assign status.valid = valid;
  assign status.done  = valid && m_ready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      slot  <= '0;
    end else if (load) begin
      valid <= 1'b1;
      slot  <= '0;
    end else if (status.done) begin
      valid <= 1'b0;
      slot  <= '0;
    end else if (valid && m_ready) begin
      slot <= slot + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bundle <= bundle_next;
    end
  end

endmodule

>>> rtl/command_prefetch_ring_feeder.sv
// ----------------------------------------------------------------------------
// command_prefetch_ring_feeder
// Turns fetched command headers into dispatch ring writes and pointer updates.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command header per request; m_axis returns one to
//   three action requests per header, tlast on the final one, tuser the
//   action kind. APB sets issue queue base and the trace and pad opcodes.
//   A header is registered on entry and decided in one pass when the result
//   register is free; its actions appear on m_axis in the cycle after the
//   decision and leave one per cycle while m_axis_tready is high. The result
//   register is the limit: the next header is decided in the cycle the last
//   action of the previous one is taken, and one more header waits in the
//   input register meanwhile. When m_axis stalls, the result and input
//   registers fill and s_axis_tready drops. Reset clears all ring, pointer
//   and trace state and restores the register defaults. PAGE_BYTES and
//   ISSUE_QUEUE_BYTES must be powers of two; the block does not check this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module command_prefetch_ring_feeder import cprf_pkg::*; #(
  parameter int PAGE_BYTES        = 4096,
  parameter int RING_PAGES        = 64,
  parameter int ISSUE_QUEUE_BYTES = 65536,
  parameter int ALIGN_BYTES       = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command_code, header_bytes, forward_bytes, trace_source, trace_length
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // ring_page, page_count, published_pages, issue_read_pointer,
  // next_fetch_address
  output logic [143:0] m_axis_tdata,
  // action_kind
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  cfg_t        cfg;
  req_t        req;
  logic        in_valid;
  logic        take;
  bundle_t     bundle_next;
  out_status_t ostat;
  result_t     cur;
  logic [63:0] read_pointer;
  logic [31:0] next_fetch;

  cprf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign take          = in_valid && (!ostat.valid || ostat.done);
  assign s_axis_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req <= s_axis_tdata[109:0];
    end
  end

  cprf_step #(
    .PAGE_BYTES        (PAGE_BYTES),
    .RING_PAGES        (RING_PAGES),
    .ISSUE_QUEUE_BYTES (ISSUE_QUEUE_BYTES),
    .ALIGN_BYTES       (ALIGN_BYTES)
  ) u_step (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .req          (req),
    .take         (take),
    .bundle       (bundle_next),
    .read_pointer (read_pointer),
    .next_fetch   (next_fetch)
  );

  cprf_out u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (take),
    .bundle_next (bundle_next),
    .m_ready     (m_axis_tready),
    .status      (ostat),
    .cur         (cur),
    .last        (m_axis_tlast)
  );

  assign m_axis_tvalid = ostat.valid;
  assign m_axis_tuser  = cur.kind;
  assign m_axis_tdata  = {3'd0, next_fetch, read_pointer, cur.published, cur.count, cur.page};

  `ASSERT_NEXT(a_load_shows, clk, rst, take, m_axis_tvalid)
  `ASSERT_HOLDS(a_no_idle_stall, clk, rst, (in_valid && !ostat.valid) |-> take)
  `ASSERT_HOLDS(a_trace_single, clk, rst,
                (m_axis_tvalid && m_axis_tuser == KIND_TRACE) |-> m_axis_tlast)
  `ASSERT_HOLDS(a_pad_not_last, clk, rst,
                (m_axis_tvalid && m_axis_tuser == KIND_PAD) |-> !m_axis_tlast)

endmodule
